// File: sv/sreseq_pkg.sv
package sreseq_pkg;

  // field widths
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned DIG_W   = 4;
  localparam int unsigned NOTE_W  = 8;
  localparam int unsigned PAT_W   = 16;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDAT_W  = 12;
  localparam int unsigned MASK_W  = 12;

  // length and span limits
  localparam int unsigned MAX_LEN  = 16;
  localparam int unsigned MAX_SPAN = 8;

  // divider sizing: 16-bit value times 7-bit span factor
  localparam int unsigned DVD_W = 23;
  localparam int unsigned DSR_W = 16;
  localparam int unsigned CNT_W = 5;
  localparam int unsigned MUL_W = 7;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_CLOCK = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RESET = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // register indexes
  localparam logic [CIDX_W-1:0] CFG_GEN_LEVEL = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_SEQ_LEN   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_SPAN      = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_HITS_A    = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_HITS_B    = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_HITS_C    = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_MASK      = 3'd6;

  // operation run on the shared divider
  typedef enum logic [2:0] {
    OP_POS  = 3'd0,
    OP_EA   = 3'd1,
    OP_EB   = 3'd2,
    OP_EC   = 3'd3,
    OP_NOTE = 3'd4
  } op_e;

  typedef struct packed {
    logic load_in;
    logic start;
    logic capture;
    logic update;
    logic load_out;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic is_clock;
  } status_t;

  // pitch class enabled in mask, n in -12..23
  function automatic logic note_on(input logic signed [6:0] n,
                                   input logic [MASK_W-1:0] mask);
    logic signed [6:0] pc;
    if (n < 0) pc = n + 7'sd12;
    else if (n >= 7'sd12) pc = n - 7'sd12;
    else pc = n;
    note_on = (mask == '0) || mask[pc[3:0]];
  endfunction

  // nearest enabled semitone, ties go lower
  function automatic logic signed [NOTE_W-1:0] snap(input logic [3:0] r,
                                                     input logic [MASK_W-1:0] mask);
    logic signed [6:0] lo;
    logic signed [6:0] hi;
    logic found;
    snap  = NOTE_W'(signed'({3'b0, r}));
    found = 1'b0;
    for (int d = 0; d <= 12; d++) begin
      lo = signed'({3'b0, r}) - 7'(d);
      hi = signed'({3'b0, r}) + 7'(d);
      if (!found && note_on(lo, mask)) begin
        snap  = NOTE_W'(lo);
        found = 1'b1;
      end else if (!found && note_on(hi, mask)) begin
        snap  = NOTE_W'(hi);
        found = 1'b1;
      end
    end
  endfunction

endpackage

// File: sv/shift_register_euclid_sequencer_unit.sv
// channel   | handshake             | payload
// ----------+-----------------------+---------------------------------------------
// in        | in_valid_i/in_stall_o | req_type_i random_digit_i random_bit_i
// out       | out_valid_o/out_stall_i | note_o trig_a_o trig_b_o trig_c_o
//           |                       | pattern_bits_o step_index_o
// cfg       | cfg_valid_i/cfg_ready_o | cfg_index_i cfg_data_i
//
// one request at a time through a shared bit-serial divider, one bit per cycle:
// a clock request runs step modulo, three trigger modulos and note scaling before
// the next input is free, a step reset or clear runs note scaling only.
// reset restores the register defaults and clears the pattern and step.
// a finished result waits in the output register while the next request is taken;
// a stalled output holds the next result back and keeps the input stalled.
module shift_register_euclid_sequencer_unit #(
  parameter int unsigned REG_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [sreseq_pkg::REQ_W-1:0]          req_type_i,
  input  logic [sreseq_pkg::DIG_W-1:0]          random_digit_i,
  input  logic                                  random_bit_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [sreseq_pkg::NOTE_W-1:0]  note_o,
  output logic                                  trig_a_o,
  output logic                                  trig_b_o,
  output logic                                  trig_c_o,
  output logic [sreseq_pkg::PAT_W-1:0]          pattern_bits_o,
  output logic [sreseq_pkg::STEP_W-1:0]         step_index_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [sreseq_pkg::CIDX_W-1:0]         cfg_index_i,
  input  logic [sreseq_pkg::CDAT_W-1:0]         cfg_data_i
);
  import sreseq_pkg::*;

  cmd_t    cmd;
  status_t status;

  // always ready; the sender must write registers only while idle, the block does not enforce it
  assign cfg_ready_o = 1'b1;

  sreseq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sreseq_dp #(
    .REG_BITS (REG_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_type_i),
    .random_digit_i (random_digit_i),
    .random_bit_i   (random_bit_i),
    .note_o         (note_o),
    .trig_a_o       (trig_a_o),
    .trig_b_o       (trig_b_o),
    .trig_c_o       (trig_c_o),
    .pattern_bits_o (pattern_bits_o),
    .step_index_o   (step_index_o)
  );

endmodule

// File: sv/sreseq_div.sv
module sreseq_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [sreseq_pkg::DVD_W-1:0]   dividend_i,
  input  logic [sreseq_pkg::CNT_W-1:0]   count_i,
  input  logic [sreseq_pkg::DSR_W-1:0]   divisor_i,
  output logic [sreseq_pkg::DVD_W-1:0]   quotient_o,
  output logic [sreseq_pkg::DSR_W-1:0]   remainder_o,
  output logic                           done_o
);
  import sreseq_pkg::*;

  logic [DVD_W-1:0] dvd_q;
  logic [DVD_W-1:0] quo_q;
  logic [DSR_W-1:0] rem_q;
  logic [DSR_W-1:0] dsr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             fits;

  // one restoring step per cycle, dividend left aligned
  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    diff  = trial - {1'b0, dsr_q};
    fits  = trial >= {1'b0, dsr_q};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= count_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      quo_q <= {quo_q[DVD_W-2:0], fits};
      rem_q <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

endmodule

// File: sv/sreseq_dp.sv
module sreseq_dp #(
  parameter int unsigned REG_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  sreseq_pkg::cmd_t                      cmd_i,
  output sreseq_pkg::status_t                   status_o,
  input  logic                                  cfg_we_i,
  input  logic [sreseq_pkg::CIDX_W-1:0]         cfg_index_i,
  input  logic [sreseq_pkg::CDAT_W-1:0]         cfg_data_i,
  input  logic [sreseq_pkg::REQ_W-1:0]          req_type_i,
  input  logic [sreseq_pkg::DIG_W-1:0]          random_digit_i,
  input  logic                                  random_bit_i,
  output logic signed [sreseq_pkg::NOTE_W-1:0]  note_o,
  output logic                                  trig_a_o,
  output logic                                  trig_b_o,
  output logic                                  trig_c_o,
  output logic [sreseq_pkg::PAT_W-1:0]          pattern_bits_o,
  output logic [sreseq_pkg::STEP_W-1:0]         step_index_o
);
  import sreseq_pkg::*;

  localparam int unsigned CAP  = (REG_BITS < MAX_LEN) ? REG_BITS : MAX_LEN;
  localparam int unsigned PW   = (REG_BITS < PAT_W) ? REG_BITS : PAT_W;
  localparam int unsigned IW   = $clog2(REG_BITS);

  // configuration
  logic [3:0]        gen_level_q;
  logic [LEN_W-1:0]  seq_len_q;
  logic [3:0]        span_q;
  logic [LEN_W-1:0]  hits_a_q;
  logic [LEN_W-1:0]  hits_b_q;
  logic [LEN_W-1:0]  hits_c_q;
  logic [MASK_W-1:0] mask_q;

  // state and held request
  logic [REG_BITS-1:0] pattern_q;
  logic [STEP_W-1:0]   step_q;
  logic [STEP_W-1:0]   pos_q;
  logic [REQ_W-1:0]    req_q;
  logic [DIG_W-1:0]    digit_q;
  logic                rbit_q;
  logic                ta_q;
  logic                tb_q;
  logic                tc_q;

  logic [LEN_W-1:0]  len;
  logic [3:0]        span;
  logic [MUL_W-1:0]  mul;
  logic [PAT_W-1:0]  pat16;
  logic [DSR_W-1:0]  den;
  logic [DSR_W-1:0]  value;
  logic [LEN_W-1:0]  hits_sel;
  logic [7:0]        euc_prod;
  logic [DVD_W-1:0]  dividend;
  logic [CNT_W-1:0]  count;
  logic [DSR_W-1:0]  divisor;
  logic [DVD_W-1:0]  quo;
  logic [DSR_W-1:0]  rem;
  logic              div_done;
  logic              fire;
  logic              new_bit;
  logic [LEN_W-1:0]  pos_next;
  logic [IW-1:0]     tap;
  logic [LEN_W-1:0]  len_m1;
  logic [6:0]        raw;
  logic [12:0]       raw_x;
  logic [3:0]        oct;
  logic [3:0]        semi;
  logic [NOTE_W-1:0] oct_x12;

  // effective length and span
  always_comb begin
    if (seq_len_q == '0) len = LEN_W'(1);
    else if (seq_len_q > LEN_W'(CAP)) len = LEN_W'(CAP);
    else len = seq_len_q;
    if (span_q == '0) span = 4'd1;
    else if (span_q > 4'(MAX_SPAN)) span = 4'(MAX_SPAN);
    else span = span_q;
    mul = MUL_W'(span) * MUL_W'(12) - MUL_W'(1);
  end

  // note value and its full-scale divisor
  always_comb begin
    pat16 = PAT_W'(pattern_q[PW-1:0]);
    den   = DSR_W'((17'd1 << len) - 17'd1);
    value = pat16 & den;
  end

  // divider operands
  always_comb begin
    unique case (cmd_i.op)
      OP_EA:   hits_sel = hits_a_q;
      OP_EB:   hits_sel = hits_b_q;
      OP_EC:   hits_sel = hits_c_q;
      default: hits_sel = hits_a_q;
    endcase
    euc_prod = pos_q * hits_sel[3:0];
    unique case (cmd_i.op)
      OP_POS: begin
        dividend = {step_q, {(DVD_W-STEP_W){1'b0}}};
        count    = CNT_W'(STEP_W);
        divisor  = DSR_W'(len);
      end
      OP_EA, OP_EB, OP_EC: begin
        dividend = {euc_prod, {(DVD_W-8){1'b0}}};
        count    = CNT_W'(8);
        divisor  = DSR_W'(len);
      end
      OP_NOTE: begin
        dividend = value * mul;
        count    = CNT_W'(DVD_W);
        divisor  = den;
      end
      default: begin
        dividend = '0;
        count    = CNT_W'(1);
        divisor  = DSR_W'(1);
      end
    endcase
  end

  sreseq_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.start),
    .dividend_i  (dividend),
    .count_i     (count),
    .divisor_i   (divisor),
    .quotient_o  (quo),
    .remainder_o (rem),
    .done_o      (div_done)
  );

  // euclidean decision for the selected hit count
  always_comb begin
    if (hits_sel == '0) fire = 1'b0;
    else if (hits_sel >= len) fire = 1'b1;
    else fire = rem < DSR_W'(hits_sel);
  end

  // bit entering the register and the next step
  always_comb begin
    len_m1   = len - 1'b1;
    tap      = len_m1[IW-1:0];
    new_bit  = (digit_q < gen_level_q) ? rbit_q : pattern_q[tap];
    pos_next = LEN_W'(pos_q) + 1'b1;
  end

  // result note
  always_comb begin
    raw     = quo[6:0];
    raw_x   = raw * 6'd43;
    oct     = raw_x[12:9];
    semi    = 4'(raw - 7'(oct) * 7'd12);
    oct_x12 = NOTE_W'(oct) * NOTE_W'(12);
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_level_q <= 4'd0;
      seq_len_q   <= LEN_W'(8);
      span_q      <= 4'd2;
      hits_a_q    <= LEN_W'(4);
      hits_b_q    <= LEN_W'(5);
      hits_c_q    <= LEN_W'(7);
      mask_q      <= MASK_W'(2741);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GEN_LEVEL: gen_level_q <= cfg_data_i[3:0];
        CFG_SEQ_LEN:   seq_len_q   <= cfg_data_i[LEN_W-1:0];
        CFG_SPAN:      span_q      <= cfg_data_i[3:0];
        CFG_HITS_A:    hits_a_q    <= cfg_data_i[LEN_W-1:0];
        CFG_HITS_B:    hits_b_q    <= cfg_data_i[LEN_W-1:0];
        CFG_HITS_C:    hits_c_q    <= cfg_data_i[LEN_W-1:0];
        CFG_MASK:      mask_q      <= cfg_data_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      step_q    <= '0;
    end else if (cmd_i.update) begin
      unique case (req_q)
        REQ_CLOCK: begin
          pattern_q <= {pattern_q[REG_BITS-2:0], new_bit};
          step_q    <= (pos_next == len) ? '0 : pos_next[STEP_W-1:0];
        end
        REQ_RESET: step_q <= '0;
        REQ_CLEAR: begin
          pattern_q <= '0;
          step_q    <= '0;
        end
        default: ;
      endcase
    end
  end

  // held request, step position and triggers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      req_q   <= req_type_i;
      digit_q <= random_digit_i;
      rbit_q  <= random_bit_i;
      ta_q    <= 1'b0;
      tb_q    <= 1'b0;
      tc_q    <= 1'b0;
    end else if (cmd_i.capture) begin
      unique case (cmd_i.op)
        OP_POS:  pos_q <= rem[STEP_W-1:0];
        OP_EA:   ta_q  <= fire;
        OP_EB:   tb_q  <= fire;
        OP_EC:   tc_q  <= fire;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      note_o         <= snap(semi, mask_q) + signed'(oct_x12);
      trig_a_o       <= ta_q;
      trig_b_o       <= tb_q;
      trig_c_o       <= tc_q;
      pattern_bits_o <= pat16;
      step_index_o   <= step_q;
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.is_clock = (req_q == REQ_CLOCK);

endmodule

// File: sv/sreseq_ctrl.sv
module sreseq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  sreseq_pkg::status_t   status_i,
  output sreseq_pkg::cmd_t      cmd_o
);
  import sreseq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_GO   = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;
  op_e        op_q;
  op_e        op_d;
  logic       out_valid_q;
  logic       out_valid_d;
  logic       accept;
  logic       out_free;

  assign accept   = (state_q == S_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  // sequencing of divider operations
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '{load_in: 1'b0, start: 1'b0, capture: 1'b0, update: 1'b0,
                load_out: 1'b0, op: op_q};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DISP;
        end
      end
      S_DISP: begin
        if (status_i.is_clock) begin
          op_d    = OP_POS;
          state_d = S_GO;
        end else begin
          state_d = S_UPD;
        end
      end
      S_GO: begin
        cmd_o.start = 1'b1;
        state_d     = S_WAIT;
      end
      S_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.capture = 1'b1;
          unique case (op_q)
            OP_POS:  begin op_d = OP_EA; state_d = S_GO;  end
            OP_EA:   begin op_d = OP_EB; state_d = S_GO;  end
            OP_EB:   begin op_d = OP_EC; state_d = S_GO;  end
            OP_EC:   state_d = S_UPD;
            OP_NOTE: state_d = S_OUT;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        op_d         = OP_NOTE;
        state_d      = S_GO;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_POS;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
